>>> rtl/core/nsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

   // Default buffer length of one sentence, terminator place included.
   localparam int MAX_LEN_DEFAULT = 75;

   // Character codes the tracker reacts to.
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   // Number of characters in the GGA tag, the dollar included.
   localparam logic [2:0] GGA_TAG_LEN = 3'd6;

   // Width of the response payload before byte padding.
   localparam int RESULT_W = 20;
   localparam int RSP_DATA_W = 24;

   // Sentence phases.
   typedef enum logic [1:0] {
      PHASE_BODY = 2'd0,
      PHASE_HEX  = 2'd1,
      PHASE_DONE = 2'd2
   } phase_type;

   // One result; the last field sits in the lowest bits.
   typedef struct packed {
      logic       overflow;
      logic       is_gga;
      logic [7:0] received_sum;
      logic [7:0] computed_sum;
      logic       star_found;
      logic       checksum_ok;
   } result_type;

   // Expected character of "$GPGGA" at a given position.
   function automatic logic [7:0] gga_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = 8'h24;
         3'd1:    ch = 8'h47;
         3'd2:    ch = 8'h50;
         3'd3:    ch = 8'h47;
         3'd4:    ch = 8'h47;
         3'd5:    ch = 8'h41;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Hex digit decode; bit 4 is set when the character is a hex digit.
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/nmea_sentence_checker.sv
//  Channel  Direction  Signals                          Payload
//  req      in         req_tvalid req_tready req_tdata  rx_byte
//  rsp      out        rsp_tvalid rsp_tready rsp_tdata  checksum result of one sentence
//
//  A new byte is taken every cycle while req_tready is high.
//  A closing newline pushes its result, at its transfer, into a
//  two-entry result queue that sets the depth of buffering.
//  req_tready drops only while both queue entries wait on rsp_tready.
//  Synchronous active-high reset clears the sentence state and the queue.
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_checker #(
   parameter int MAX_LEN = nsc_pkg::MAX_LEN_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,  // [7:0] rx_byte
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [0] checksum_ok, [1] star_found, [9:2] computed_sum, [17:10] received_sum,
   // [18] is_gga, [19] overflow, [23:20] zero
   output logic [nsc_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import nsc_pkg::*;

   logic       req_xfer;
   logic       result_valid;
   result_type result;
   result_type out_data;
   logic       fifo_full;
   logic [1:0] fifo_count;

   assign req_tready = !fifo_full;
   assign req_xfer   = req_tvalid && req_tready;

   // Sentence state and result logic.
   nsc_tracker #(
      .MAX_LEN(MAX_LEN)
   ) u_tracker (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_xfer),
      .byte_data   (req_tdata),
      .result_valid(result_valid),
      .result      (result)
   );

   // Result queue decouples the two sides.
   nsc_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (result_valid),
      .push_data(result),
      .full     (fifo_full),
      .count    (fifo_count),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (out_data)
   );

   assign rsp_tdata = {(RSP_DATA_W - RESULT_W)'(0), out_data};

`ifndef ASSERT_OFF
   // A transfer of anything but a newline never adds a queued result.
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tdata != CHAR_NEWLINE) |=> (fifo_count <= $past(fifo_count)))
      else $error("result queued for a byte that is not a newline");

   // Input stalls only while the response side holds results.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && fifo_count == 2'd2))
      else $error("input stalled without a full result queue");

   // A queued result is never dropped while the consumer stalls.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("pending result lost during stall");

   // An accepted closing byte never finds the queue full.
   assert property (@(posedge clock) disable iff (reset)
      result_valid |-> !fifo_full)
      else $error("result pushed into a full queue");
`endif

endmodule

`default_nettype wire

>>> rtl/core/nsc_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

module nsc_tracker #(
   parameter int MAX_LEN = nsc_pkg::MAX_LEN_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               byte_valid,
   input  wire logic [7:0]         byte_data,
   output logic                    result_valid,
   output nsc_pkg::result_type     result
);
   import nsc_pkg::*;

   localparam int LEN_W = $clog2(MAX_LEN);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN - 1);

   logic             in_sentence_ff, in_sentence_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       xor_acc_ff, xor_acc_in;
   logic [7:0]       rx_sum_ff, rx_sum_in;
   logic [1:0]       hex_count_ff, hex_count_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [2:0]       prefix_pos_ff, prefix_pos_in;
   logic             prefix_match_ff, prefix_match_in;
   logic             overflowed_ff, overflowed_in;
   logic [4:0]       hex;

   assign hex = hex_decode(byte_data);

   // Next state of the sentence tracker and the result on a closing newline.
   always_comb begin
      in_sentence_in  = in_sentence_ff;
      phase_in        = phase_ff;
      xor_acc_in      = xor_acc_ff;
      rx_sum_in       = rx_sum_ff;
      hex_count_in    = hex_count_ff;
      length_in       = length_ff;
      prefix_pos_in   = prefix_pos_ff;
      prefix_match_in = prefix_match_ff;
      overflowed_in   = overflowed_ff;
      result_valid    = 1'b0;

      if (byte_valid && byte_data == CHAR_DOLLAR) begin
         in_sentence_in  = 1'b1;
         phase_in        = PHASE_BODY;
         xor_acc_in      = 8'd0;
         rx_sum_in       = 8'd0;
         hex_count_in    = 2'd0;
         length_in       = LEN_W'(1);
         prefix_pos_in   = 3'd1;
         prefix_match_in = 1'b1;
         overflowed_in   = 1'b0;
      end else if (byte_valid && in_sentence_ff) begin
         // Every stored byte counts against the buffer, the newline too.
         if (length_ff >= LEN_LIMIT) begin
            overflowed_in = 1'b1;
         end else begin
            length_in = length_ff + LEN_W'(1);
         end

         if (byte_data == CHAR_NEWLINE) begin
            result_valid   = 1'b1;
            in_sentence_in = 1'b0;
         end else begin
            if (prefix_pos_ff < GGA_TAG_LEN) begin
               if (byte_data != gga_char(prefix_pos_ff)) begin
                  prefix_match_in = 1'b0;
               end
               prefix_pos_in = prefix_pos_ff + 3'd1;
            end

            case (phase_ff)
               PHASE_BODY: begin
                  if (byte_data == CHAR_STAR) begin
                     phase_in = PHASE_HEX;
                  end else begin
                     xor_acc_in = xor_acc_ff ^ byte_data;
                  end
               end
               PHASE_HEX: begin
                  if (!hex[4]) begin
                     phase_in = PHASE_DONE;
                  end else begin
                     rx_sum_in    = {rx_sum_ff[3:0], hex[3:0]};
                     hex_count_in = hex_count_ff + 2'd1;
                     if (hex_count_ff != 2'd0) begin
                        phase_in = PHASE_DONE;
                     end
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // Result fields, read from the state before the newline; overflow also counts the newline.
   always_comb begin
      result.star_found   = (phase_ff != PHASE_BODY);
      result.computed_sum = xor_acc_ff;
      result.received_sum = rx_sum_ff;
      result.is_gga       = prefix_match_ff && (prefix_pos_ff == GGA_TAG_LEN);
      result.overflow     = overflowed_in;
      result.checksum_ok  = (phase_ff != PHASE_BODY) && (hex_count_ff != 2'd0) &&
                            (xor_acc_ff == rx_sum_ff) && !overflowed_in;
   end

   // Tracker state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff  <= 1'b0;
         phase_ff        <= PHASE_BODY;
         xor_acc_ff      <= 8'd0;
         rx_sum_ff       <= 8'd0;
         hex_count_ff    <= 2'd0;
         length_ff       <= '0;
         prefix_pos_ff   <= 3'd0;
         prefix_match_ff <= 1'b0;
         overflowed_ff   <= 1'b0;
      end else begin
         in_sentence_ff  <= in_sentence_in;
         phase_ff        <= phase_in;
         xor_acc_ff      <= xor_acc_in;
         rx_sum_ff       <= rx_sum_in;
         hex_count_ff    <= hex_count_in;
         length_ff       <= length_in;
         prefix_pos_ff   <= prefix_pos_in;
         prefix_match_ff <= prefix_match_in;
         overflowed_ff   <= overflowed_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/nsc_rsp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module nsc_rsp_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire nsc_pkg::result_type push_data,
   output logic                     full,
   output logic [1:0]               count,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output nsc_pkg::result_type      out_data
);
   import nsc_pkg::*;

   result_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign full      = (count_ff == 2'd2);
   assign count     = count_ff;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire
